// ----- sv/pre_pkg.sv -----
package pre_pkg;

    localparam int PreMaxLen     = 64;
    localparam int PreOffsetBits = 32;

    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 7;

    localparam logic [CfgIdxW-1:0] CfgMinLength  = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgWithOffset = 1'b1;

    localparam int InDataW  = 8;
    localparam int OutDataW = 40;
    localparam int OutUserW = 2;

    typedef struct packed {
        logic take_input;
        logic issue_read;
        logic emit_burst;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic burst_start;
        logic burst_last;
    } t_dp_status;

endpackage

// ----- sv/printable_run_extractor.sv -----
// Scans a byte stream for runs of printable characters and reports every run of at least
// min_length bytes as a string, closed by a newline beat. A byte that yields no result or
// exactly one result (a pass-through byte or a terminator) needs no replay, so the input runs
// at one byte per cycle while the output side keeps up and no burst is replayed. When a run
// reaches the threshold, its N buffered bytes are replayed from the run store; each replayed
// beat needs a registered read of that memory and then a load of the output register, so the
// burst holds the input until it ends. The run store needs no initialization after reset.
module printable_run_extractor #(
    parameter int MAX_LEN     = pre_pkg::PreMaxLen,
    parameter int OFFSET_BITS = pre_pkg::PreOffsetBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pre_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [pre_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // data_byte
    input  logic [pre_pkg::InDataW-1:0]   s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_byte, string_offset
    output logic [pre_pkg::OutDataW-1:0]  m_axis_tdata,
    // first_of_string, terminator
    output logic [pre_pkg::OutUserW-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast
);
    import pre_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    pre_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pre_datapath #(
        .MAX_LEN     (MAX_LEN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- sv/pre_ctrl.sv -----
module pre_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pre_pkg::t_dp_status i_status,
    output pre_pkg::t_ctrl_cmd  o_cmd
);
    import pre_pkg::*;

    localparam logic [1:0] StAccept = 2'd0;
    localparam logic [1:0] StRead   = 2'd1;
    localparam logic [1:0] StEmit   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.take_input = 1'b0;
        o_cmd.issue_read = 1'b0;
        o_cmd.emit_burst = 1'b0;
        case (r_state)
            StAccept: begin
                o_cmd.take_input = 1'b1;
                if (i_status.burst_start) begin
                    n_state = StRead;
                end
            end
            StRead: begin
                o_cmd.issue_read = 1'b1;
                n_state          = StEmit;
            end
            StEmit: begin
                if (i_status.out_free) begin
                    o_cmd.emit_burst = 1'b1;
                    n_state          = i_status.burst_last ? StAccept : StRead;
                end
            end
            default: begin
                n_state = StAccept;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StAccept;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/pre_datapath.sv -----
module pre_datapath #(
    parameter int MAX_LEN     = pre_pkg::PreMaxLen,
    parameter int OFFSET_BITS = pre_pkg::PreOffsetBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pre_pkg::t_ctrl_cmd            i_cmd,
    output pre_pkg::t_dp_status           o_status,
    input  logic                          i_cfg_we,
    input  logic [pre_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [pre_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pre_pkg::InDataW-1:0]   s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pre_pkg::OutDataW-1:0]  m_axis_tdata,
    output logic [pre_pkg::OutUserW-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast
);
    import pre_pkg::*;

    localparam int CntW = $clog2(MAX_LEN + 1);
    localparam int AdrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CfgDataW-1:0] MaxLenC = CfgDataW'(MAX_LEN);
    localparam logic [CntW-1:0]     MaxCnt  = CntW'(MAX_LEN);
    localparam logic [7:0]          NlCode  = 8'h0A;

    function automatic logic is_printable(input logic [7:0] b);
        is_printable = b inside {[8'h21 : 8'h7E], 8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    logic [7:0] r_run_store [MAX_LEN];
    logic [7:0] r_rd_data;

    logic [CfgDataW-1:0]    r_min_length;
    logic                   r_with_offset;
    logic [CntW-1:0]        r_count, n_count;
    logic                   r_reporting, n_reporting;
    logic [OFFSET_BITS-1:0] r_byte_pos, n_byte_pos;
    logic [OFFSET_BITS-1:0] r_run_start, n_run_start;
    logic [CntW-1:0]        r_burst_len, n_burst_len;
    logic [CntW-1:0]        r_idx, n_idx;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [31:0] r_out_off, n_out_off;
    logic        r_out_first, n_out_first;
    logic        r_out_term, n_out_term;
    logic        r_out_last, n_out_last;

    logic                w_out_free;
    logic                w_accept;
    logic                w_print;
    logic                w_store_we;
    logic                w_qualify;
    logic                w_burst_last;
    logic [CntW-1:0]     w_count_inc;
    logic [CfgDataW-1:0] w_thr;
    logic [63:0]         w_start_wide;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = i_cmd.take_input && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_print       = is_printable(s_axis_tdata);

    assign w_thr = (r_min_length == '0) ? CfgDataW'(1) :
                   ((r_min_length > MaxLenC) ? MaxLenC : r_min_length);
    assign w_count_inc  = (r_count < MaxCnt) ? (r_count + CntW'(1)) : r_count;
    assign w_qualify    = CfgDataW'(w_count_inc) >= w_thr;
    assign w_store_we   = w_accept && !s_axis_tlast && !r_reporting && w_print
                          && (r_count < MaxCnt);
    assign w_burst_last = (r_idx + CntW'(1)) == r_burst_len;
    assign w_start_wide = 64'(r_run_start);

    assign o_status.out_free    = w_out_free;
    assign o_status.burst_start = w_accept && !s_axis_tlast && !r_reporting && w_print
                                  && w_qualify;
    assign o_status.burst_last  = w_burst_last;

    always_comb begin
        n_count     = r_count;
        n_reporting = r_reporting;
        n_byte_pos  = r_byte_pos;
        n_run_start = r_run_start;
        n_burst_len = r_burst_len;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_off   = r_out_off;
        n_out_first = r_out_first;
        n_out_term  = r_out_term;
        n_out_last  = r_out_last;
        if (w_accept) begin
            if (s_axis_tlast) begin
                if (r_reporting) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = NlCode;
                    n_out_off   = '0;
                    n_out_first = 1'b0;
                    n_out_term  = 1'b1;
                    n_out_last  = 1'b1;
                end
                n_count     = '0;
                n_reporting = 1'b0;
                n_byte_pos  = '0;
                n_run_start = '0;
            end else begin
                n_byte_pos = r_byte_pos + OFFSET_BITS'(1);
                if (r_reporting) begin
                    n_out_valid = 1'b1;
                    n_out_off   = '0;
                    n_out_first = 1'b0;
                    n_out_last  = 1'b1;
                    if (w_print) begin
                        n_out_byte = s_axis_tdata;
                        n_out_term = 1'b0;
                    end else begin
                        n_out_byte  = NlCode;
                        n_out_term  = 1'b1;
                        n_reporting = 1'b0;
                        n_count     = '0;
                    end
                end else if (w_print) begin
                    if (r_count == '0) begin
                        n_run_start = r_byte_pos;
                    end
                    if (w_qualify) begin
                        n_burst_len = w_count_inc;
                        n_idx       = '0;
                        n_reporting = 1'b1;
                        n_count     = '0;
                    end else begin
                        n_count = w_count_inc;
                    end
                end else begin
                    n_count = '0;
                end
            end
        end
        if (i_cmd.emit_burst) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_rd_data;
            n_out_off   = (r_idx == '0 && r_with_offset) ? w_start_wide[31:0] : 32'd0;
            n_out_first = (r_idx == '0);
            n_out_term  = 1'b0;
            n_out_last  = w_burst_last;
            n_idx       = r_idx + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_run_store[r_count[AdrW-1:0]] <= s_axis_tdata;
        end
        if (i_cmd.issue_read) begin
            r_rd_data <= r_run_store[r_idx[AdrW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length  <= CfgDataW'(4);
            r_with_offset <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgMinLength:  r_min_length  <= i_cfg_data;
                CfgWithOffset: r_with_offset <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_reporting <= 1'b0;
            r_byte_pos  <= '0;
            r_run_start <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_reporting <= n_reporting;
            r_byte_pos  <= n_byte_pos;
            r_run_start <= n_run_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst_len <= n_burst_len;
        r_idx       <= n_idx;
        r_out_byte  <= n_out_byte;
        r_out_off   <= n_out_off;
        r_out_first <= n_out_first;
        r_out_term  <= n_out_term;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_off, r_out_byte};
    assign m_axis_tuser  = {r_out_term, r_out_first};
    assign m_axis_tlast  = r_out_last;

endmodule
